@@ rtl/mcc_pkg.sv @@
// Shared types and constants for the minimum coin change solver.
package mcc_pkg;

   localparam int MAX_AMOUNT = 63;
   localparam int MAX_COINS  = 6;
   localparam int TBL_DEPTH  = MAX_AMOUNT + 1;
   localparam int ADDR_W     = $clog2(TBL_DEPTH);
   localparam int AMT_W      = 6;
   localparam int COIN_W     = 6;
   localparam int CNT_W      = 7;
   localparam int NCOIN_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   localparam logic [CNT_W-1:0]   UNREACHED  = 7'd127;
   localparam logic [NCOIN_W-1:0] NCOIN_MAX  = NCOIN_W'(MAX_COINS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COIN_COUNT = 3'd0,
      CSR_COIN_A     = 3'd1,
      CSR_COIN_B     = 3'd2,
      CSR_COIN_C     = 3'd3,
      CSR_COIN_D     = 3'd4,
      CSR_COIN_E     = 3'd5,
      CSR_COIN_F     = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_FILL,
      ST_HDR,
      ST_TR_RD,
      ST_TR_WAIT
   } state_type;

   // One table entry: fewest coins and the first coin that reached it.
   typedef struct packed {
      logic [CNT_W-1:0]  best;
      logic [COIN_W-1:0] coin;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [NCOIN_W-1:0]                  ncoins;
      logic [MAX_COINS-1:0][COIN_W-1:0]    coins;
   } cfg_type;

   // One result beat handed from the sequencer to the output register.
   typedef struct packed {
      logic              load;
      logic              found;
      logic [AMT_W-1:0]  min_count;
      logic              is_path_coin;
      logic [COIN_W-1:0] coin_value;
      logic              last;
   } beat_type;

endpackage

@@ rtl/mcc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module mcc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mcc_ctrl.sv @@
// Table fill and trace-back sequencer for the coin change solver.
module mcc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mcc_pkg::AMT_W-1:0] amount,
   input  mcc_pkg::cfg_type          cfg,
   input  logic                      out_free,
   output logic                      idle,
   output mcc_pkg::beat_type         beat,
   output logic                      rd_en,
   output logic [mcc_pkg::ADDR_W-1:0] rd_addr,
   input  mcc_pkg::entry_type        rd_data,
   output logic                      wr_en,
   output logic [mcc_pkg::ADDR_W-1:0] wr_addr,
   output mcc_pkg::entry_type        wr_data
);
   import mcc_pkg::*;

   state_type          state_ff, state_in;
   logic [AMT_W-1:0]   amt_ff, amt_in;
   logic [AMT_W-1:0]   pos_ff, pos_in;
   logic [NCOIN_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0]   cur_best_ff, cur_best_in;
   logic [COIN_W-1:0]  cur_coin_ff, cur_coin_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [COIN_W-1:0]  rd_coin_ff, rd_coin_in;

   logic [COIN_W-1:0]  coin_sel;
   logic               issue;
   logic [CNT_W-1:0]   upd_best;
   logic [COIN_W-1:0]  upd_coin;
   logic [CNT_W-1:0]   cand;
   logic [AMT_W-1:0]   rem;
   logic               found;

   always_comb begin
      case (j_ff)
         3'd0:    coin_sel = cfg.coins[0];
         3'd1:    coin_sel = cfg.coins[1];
         3'd2:    coin_sel = cfg.coins[2];
         3'd3:    coin_sel = cfg.coins[3];
         3'd4:    coin_sel = cfg.coins[4];
         3'd5:    coin_sel = cfg.coins[5];
         default: coin_sel = '0;
      endcase
   end

   assign issue = (j_ff < cfg.ncoins) && (coin_sel != '0) && (coin_sel <= pos_ff);

   // Compare the entry read last cycle against the running best.
   assign cand = rd_data.best + CNT_W'(1);
   always_comb begin
      upd_best = cur_best_ff;
      upd_coin = cur_coin_ff;
      if (rd_vld_ff && (rd_data.best != UNREACHED) && (cand < cur_best_ff)) begin
         upd_best = cand;
         upd_coin = rd_coin_ff;
      end
   end

   assign found = (cur_best_ff != UNREACHED);
   assign rem   = pos_ff - rd_data.coin;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      amt_ff      <= amt_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      cur_best_ff <= cur_best_in;
      cur_coin_ff <= cur_coin_in;
      rd_coin_ff  <= rd_coin_in;
   end

   always_comb begin
      state_in    = state_ff;
      amt_in      = amt_ff;
      pos_in      = pos_ff;
      j_in        = j_ff;
      cur_best_in = cur_best_ff;
      cur_coin_in = cur_coin_ff;
      rd_vld_in   = 1'b0;
      rd_coin_in  = rd_coin_ff;
      rd_en       = 1'b0;
      rd_addr     = pos_ff;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = '0;
      beat        = '0;
      idle        = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               amt_in   = amount;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data.best  = '0;
            wr_data.coin  = '0;
            j_in          = '0;
            if (amt_ff == '0) begin
               cur_best_in = '0;
               state_in    = ST_HDR;
            end else begin
               pos_in      = AMT_W'(1);
               cur_best_in = UNREACHED;
               cur_coin_in = '0;
               state_in    = ST_FILL;
            end
         end
         ST_FILL: begin
            if (j_ff == cfg.ncoins) begin
               // Last compare lands here; write the entry, no read this cycle.
               wr_en        = 1'b1;
               wr_data.best = upd_best;
               wr_data.coin = upd_coin;
               j_in         = '0;
               if (pos_ff == amt_ff) begin
                  cur_best_in = upd_best;
                  state_in    = ST_HDR;
               end else begin
                  pos_in      = pos_ff + AMT_W'(1);
                  cur_best_in = UNREACHED;
                  cur_coin_in = '0;
               end
            end else begin
               rd_en       = issue;
               rd_addr     = pos_ff - coin_sel;
               rd_vld_in   = issue;
               rd_coin_in  = coin_sel;
               cur_best_in = upd_best;
               cur_coin_in = upd_coin;
               j_in        = j_ff + NCOIN_W'(1);
            end
         end
         ST_HDR: begin
            if (out_free) begin
               beat.load      = 1'b1;
               beat.found     = found;
               beat.min_count = found ? cur_best_ff[AMT_W-1:0] : '0;
               beat.last      = !found || (cur_best_ff == '0);
               pos_in         = amt_ff;
               state_in       = beat.last ? ST_IDLE : ST_TR_RD;
            end
         end
         ST_TR_RD: begin
            rd_en    = 1'b1;
            state_in = ST_TR_WAIT;
         end
         ST_TR_WAIT: begin
            if (out_free) begin
               beat.load         = 1'b1;
               beat.found        = 1'b1;
               beat.min_count    = cur_best_ff[AMT_W-1:0];
               beat.is_path_coin = 1'b1;
               beat.coin_value   = rd_data.coin;
               beat.last         = (rem == '0);
               pos_in            = rem;
               state_in          = beat.last ? ST_IDLE : ST_TR_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("table read and write issued in the same cycle");

   a_fill_reads_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && rd_en) |-> (rd_addr < pos_ff))
      else $error("fill read of an entry not yet written");

   a_coin_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (j_ff <= cfg.ncoins))
      else $error("coin index ran past the coin count");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      beat.load |-> out_free)
      else $error("result beat loaded over a stalled beat");

   a_read_feeds_compare: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(rd_en))
      else $error("compare used data from no read");

endmodule

@@ rtl/min_coin_change_solver.sv @@
// Top level of the minimum coin change solver: registers, table and output stage.
//
// Usage:
//   Configure coin_count (csr index 0) and coin_a..coin_f (indexes 1..6) through
//   the csr port while the block is idle; a write lands in its register at the clock edge.
//   Send a target amount as one req beat. The block fills a table of fewest
//   coins for every amount up to the target, then sends a header rsp beat with
//   found and min_count, followed, when found and nonzero, by one rsp beat per
//   path coin traced back from the target; the final beat has rsp_last set.
//   An amount is worked in steps: entry zero is seeded, then each amount
//   from 1 to the target is filled, paced by the single read port of the table
//   memory (one coin lookup per cycle, then a write-back of the entry). The
//   header follows, and each path coin takes a table read, then a load.
//   req_ready is high only between solves; one amount is worked at a time.
//   A single output register holds the current rsp beat: when the receiver
//   stalls, the sequencer waits on it and resumes when the beat is taken.
//   Reset clears control state and the registers (coin_count 0, coins 1); the
//   table holds no reset value, since every solve writes entries before reading.
module min_coin_change_solver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mcc_pkg::AMT_W-1:0]     req_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [mcc_pkg::AMT_W-1:0]     rsp_min_count,
   output logic                          rsp_is_path_coin,
   output logic [mcc_pkg::COIN_W-1:0]    rsp_coin_value,
   output logic                          rsp_last,
   input  logic                          csr_write_en,
   input  logic [mcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mcc_pkg::*;

   logic [NCOIN_W-1:0]               ncoin_ff, ncoin_in;
   logic [MAX_COINS-1:0][COIN_W-1:0] coin_ff, coin_in;
   cfg_type                          cfg;

   logic                             idle;
   logic                             out_free;
   beat_type                         beat;

   logic                             rd_en;
   logic [ADDR_W-1:0]                rd_addr;
   entry_type                        rd_data;
   logic                             wr_en;
   logic [ADDR_W-1:0]                wr_addr;
   entry_type                        wr_data;

   logic                             rsp_valid_ff, rsp_valid_in;
   beat_type                         rsp_ff, rsp_in;

   // Register writes; a write to index seven drops silently.
   always_comb begin
      ncoin_in = ncoin_ff;
      coin_in  = coin_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_COIN_COUNT: ncoin_in   = csr_wdata[NCOIN_W-1:0];
            CSR_COIN_A:     coin_in[0] = csr_wdata[COIN_W-1:0];
            CSR_COIN_B:     coin_in[1] = csr_wdata[COIN_W-1:0];
            CSR_COIN_C:     coin_in[2] = csr_wdata[COIN_W-1:0];
            CSR_COIN_D:     coin_in[3] = csr_wdata[COIN_W-1:0];
            CSR_COIN_E:     coin_in[4] = csr_wdata[COIN_W-1:0];
            CSR_COIN_F:     coin_in[5] = csr_wdata[COIN_W-1:0];
            default: begin
               ncoin_in = ncoin_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncoin_ff <= '0;
         for (int k = 0; k < MAX_COINS; k++) begin
            coin_ff[k] <= COIN_W'(1);
         end
      end else begin
         ncoin_ff <= ncoin_in;
         coin_ff  <= coin_in;
      end
   end

   // Saturate the coin count to the number of coin registers.
   assign cfg.ncoins = (ncoin_ff > NCOIN_MAX) ? NCOIN_MAX : ncoin_ff;
   assign cfg.coins  = coin_ff;

   assign req_ready = idle;

   mcc_ram #(
      .DEPTH (TBL_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   mcc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .amount   (req_amount),
      .cfg      (cfg),
      .out_free (out_free),
      .idle     (idle),
      .beat     (beat),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   // Output register: advance on a new beat, drop valid once taken.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (beat.load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = beat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_ff.found;
   assign rsp_min_count    = rsp_ff.min_count;
   assign rsp_is_path_coin = rsp_ff.is_path_coin;
   assign rsp_coin_value   = rsp_ff.coin_value;
   assign rsp_last         = rsp_ff.last;

endmodule
